// ===== rtl/hfe_pkg.sv =====
// hfe_pkg: shared constants and helper functions for the hamming frame encoder
// no dependencies; used by hfe_front, hfe_back and the top level
`default_nettype none

package hfe_pkg;

    // data bits gathered into one codeword frame
    localparam int DATA_BITS_DEF = 26;

    // entries in the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // output byte width
    localparam int BYTE_W = 8;

    // smallest r with 2^r >= m + r + 1, capped at 7
    function automatic int parity_bit_count(input int m);
        int r;
        r = 1;
        for (int j = 1; j < 7; j++)
        begin
            if ((1 << r) < (m + r + 1))
            begin
                r = r + 1;
            end
        end
        return r;
    endfunction

    // width that holds the values 0 .. v
    function automatic int count_width(input int v);
        return $clog2(v + 1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hfe_queue.sv =====
// hfe_queue: small register queue of encode jobs between front and back
// generic on width and depth; no package dependencies
`default_nettype none

module hfe_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hfe_front.sv =====
// hfe_front: accepts input bytes, gathers data bits into frames, issues encode jobs
// depends on hfe_pkg; feeds hfe_queue
`default_nettype none

module hfe_front #(
    parameter int DATA_BITS = hfe_pkg::DATA_BITS_DEF,
    parameter int MW        = hfe_pkg::count_width(DATA_BITS),
    parameter int JW        = DATA_BITS + MW + 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          has_byte,
    input  wire logic          end_of_data,
    output logic               job_valid,
    input  wire logic          job_ready,
    output logic [JW-1:0]      job_data
);

    localparam int KW = (MW > 4) ? MW : 4;

    logic                 busy_reg, busy_next;
    logic [7:0]           bits_reg, bits_next;
    logic [3:0]           rem_reg, rem_next;
    logic                 end_reg, end_next;
    logic [DATA_BITS-1:0] collect_reg, collect_next;
    logic [MW-1:0]        dcnt_reg, dcnt_next;

    logic [KW-1:0]          space, k;
    logic [DATA_BITS+7:0]   merged;
    logic [DATA_BITS-1:0]   new_collect, job_bits;
    logic [MW-1:0]          new_dcnt;
    logic [3:0]             rem_new;
    logic                   full, push_tail, push, fire, done, accept;

    always_comb
    begin
        // bits the current frame still takes, and bits taken this cycle
        space       = KW'(DATA_BITS) - KW'(dcnt_reg);
        k           = (KW'(rem_reg) < space) ? KW'(rem_reg) : space;
        merged      = ({8'b0, collect_reg} << k)
                    | ({{DATA_BITS{1'b0}}, bits_reg} >> (KW'(8) - k));
        new_collect = merged[DATA_BITS-1:0];
        new_dcnt    = dcnt_reg + MW'(k);
        rem_new     = rem_reg - 4'(k);
        full        = (new_dcnt == MW'(DATA_BITS));
        push_tail   = !full && (rem_new == 4'd0) && end_reg;
        push        = full || push_tail;
        // left-align so the first data bit sits at the top
        job_bits    = new_collect << (MW'(DATA_BITS) - new_dcnt);

        job_valid = busy_reg && push;
        job_data  = {end_reg && (rem_new == 4'd0), new_dcnt, job_bits};

        fire     = busy_reg && (!push || job_ready);
        done     = fire && (rem_new == 4'd0);
        in_ready = !busy_reg || done;
        accept   = in_valid && in_ready;

        busy_next    = busy_reg;
        bits_next    = bits_reg;
        rem_next     = rem_reg;
        end_next     = end_reg;
        collect_next = collect_reg;
        dcnt_next    = dcnt_reg;

        if (fire)
        begin
            bits_next = bits_reg << k;
            rem_next  = rem_new;
            busy_next = (rem_new != 4'd0);
            if (push)
            begin
                collect_next = '0;
                dcnt_next    = '0;
            end
            else
            begin
                collect_next = new_collect;
                dcnt_next    = new_dcnt;
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            bits_next = data_byte;
            rem_next  = has_byte ? 4'd8 : 4'd0;
            end_next  = end_of_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            rem_reg     <= '0;
            end_reg     <= 1'b0;
            collect_reg <= '0;
            dcnt_reg    <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            rem_reg     <= rem_next;
            end_reg     <= end_next;
            collect_reg <= collect_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hfe_back.sv =====
// hfe_back: builds the hamming codeword of each job and packs it into output bytes
// depends on hfe_pkg; fed by hfe_queue
`default_nettype none

module hfe_back #(
    parameter int DATA_BITS = hfe_pkg::DATA_BITS_DEF,
    parameter int MW        = hfe_pkg::count_width(DATA_BITS),
    parameter int JW        = DATA_BITS + MW + 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire logic [JW-1:0] job_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         out_byte,
    output logic               last_out
);

    localparam int RB  = hfe_pkg::parity_bit_count(DATA_BITS);
    localparam int CW  = DATA_BITS + RB;
    localparam int CWR = (CW > hfe_pkg::BYTE_W) ? CW : hfe_pkg::BYTE_W;
    localparam int NW  = hfe_pkg::count_width(CWR);

    // codeword with position 1 in the top bit
    function automatic logic [CW-1:0] encode(input logic [DATA_BITS-1:0] d);
        logic [CW:1]   w;
        logic [CW-1:0] res;
        logic          p;
        int            di;
        int            pos;
        int            i;
        w  = '0;
        di = 0;
        for (pos = 1; pos <= CW; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                w[pos] = d[DATA_BITS - 1 - di];
                di     = di + 1;
            end
        end
        for (i = 0; i < RB; i++)
        begin
            p = 1'b0;
            for (pos = 1; pos <= CW; pos++)
            begin
                if ((((pos >> i) & 1) != 0) && (pos != (1 << i)))
                begin
                    p = p ^ w[pos];
                end
            end
            w[1 << i] = p;
        end
        for (pos = 1; pos <= CW; pos++)
        begin
            res[CW - pos] = w[pos];
        end
        return res;
    endfunction

    logic [CWR-1:0] cw_reg, cw_next;
    logic [NW-1:0]  cw_cnt_reg, cw_cnt_next;
    logic           end_reg, end_next;
    logic           active_reg, active_next;
    logic [6:0]     acc_reg, acc_next;
    logic [2:0]     acc_cnt_reg, acc_cnt_next;
    logic           ovalid_reg, ovalid_next;
    logic [7:0]     obyte_reg, obyte_next;
    logic           olast_reg, olast_next;

    logic [DATA_BITS-1:0] hd_bits;
    logic [MW-1:0]        hd_m;
    logic                 hd_last;
    logic [NW-1:0]        hd_n;
    logic                 out_free;
    logic [NW:0]          tot;
    logic [3:0]           take;
    logic [14:0]          hi;
    logic [7:0]           emit_byte;
    logic [2:0]           cw_lo;

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign last_out  = olast_reg;

    always_comb
    begin
        hd_bits = job_data[DATA_BITS-1:0];
        hd_m    = job_data[DATA_BITS +: MW];
        hd_last = job_data[JW-1];
        hd_n    = (hd_m == '0) ? '0
                : NW'(hd_m) + NW'(hfe_pkg::parity_bit_count(int'(hd_m)));

        job_ready = !active_reg;
        out_free  = !ovalid_reg || out_ready;

        // byte from the held bits followed by the head of the codeword
        tot       = (NW + 1)'(acc_cnt_reg) + (NW + 1)'(cw_cnt_reg);
        take      = 4'd8 - 4'(acc_cnt_reg);
        hi        = {8'b0, acc_reg} << take;
        emit_byte = hi[7:0] | (cw_reg[CWR-1 -: 8] >> acc_cnt_reg);
        cw_lo     = cw_cnt_reg[2:0];

        cw_next      = cw_reg;
        cw_cnt_next  = cw_cnt_reg;
        end_next     = end_reg;
        active_next  = active_reg;
        acc_next     = acc_reg;
        acc_cnt_next = acc_cnt_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        obyte_next   = obyte_reg;
        olast_next   = olast_reg;

        if (!active_reg)
        begin
            if (job_valid)
            begin
                cw_next     = CWR'(encode(hd_bits)) << (CWR - CW);
                cw_cnt_next = hd_n;
                end_next    = hd_last;
                active_next = 1'b1;
            end
        end
        else if (out_free)
        begin
            if (tot >= (NW + 1)'(8))
            begin
                ovalid_next  = 1'b1;
                obyte_next   = emit_byte;
                olast_next   = end_reg && (tot == (NW + 1)'(8));
                cw_next      = cw_reg << take;
                cw_cnt_next  = cw_cnt_reg - NW'(take);
                acc_next     = '0;
                acc_cnt_next = '0;
                active_next  = (tot != (NW + 1)'(8));
            end
            else if (end_reg)
            begin
                // flush: zero padding comes from the cleared low codeword bits
                if (tot != '0)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = emit_byte;
                    olast_next  = 1'b1;
                end
                cw_cnt_next  = '0;
                acc_next     = '0;
                acc_cnt_next = '0;
                active_next  = 1'b0;
            end
            else
            begin
                // too few bits for a byte, keep them for the next codeword
                acc_next     = (acc_reg << cw_lo) | (cw_reg[CWR-1 -: 7] >> (3'd7 - cw_lo));
                acc_cnt_next = tot[2:0];
                cw_cnt_next  = '0;
                active_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_cnt_reg  <= '0;
            end_reg     <= 1'b0;
            active_reg  <= 1'b0;
            acc_reg     <= '0;
            acc_cnt_reg <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            cw_cnt_reg  <= cw_cnt_next;
            end_reg     <= end_next;
            active_reg  <= active_next;
            acc_reg     <= acc_next;
            acc_cnt_reg <= acc_cnt_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg    <= cw_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

// ===== rtl/hamming_frame_encoder_unit.sv =====
// hamming_frame_encoder_unit: top level of the hamming frame encoder
// depends on hfe_pkg, hfe_front, hfe_queue and hfe_back
//
// Bytes come in on the input channel and are split into bits, most
// significant first. Every DATA_BITS data bits form a frame, which is
// turned into a Hamming codeword (check bits at the power-of-two
// positions, each the even parity of the positions carrying that index
// bit); codewords are sent position 1 first and packed MSB first into
// output bytes. A transaction with end_of_data set flushes: a partial
// frame is encoded with its own smaller check-bit count, a partial byte is
// zero padded, the final byte carries last_out, and all state clears for
// the next stream. A transaction with neither has_byte nor end_of_data
// does nothing. Timing: the front takes one input byte per cycle while
// the job queue accepts its jobs, and holds in_ready low until it
// finishes a byte in which a frame boundary falls. The back loads each
// codeword into its shift register, then sends one byte per cycle while
// the output register is free, and parks fewer than eight leftover bits
// for the next codeword before it takes the next job. For 26 data bits
// eight frames give 31 output bytes. A QUEUE_DEPTH job queue sits between
// the two, and the output register holds each byte until out_ready takes
// it; a new byte forms only when the register is empty or being taken.
`default_nettype none

module hamming_frame_encoder_unit #(
    parameter int DATA_BITS   = hfe_pkg::DATA_BITS_DEF,
    parameter int QUEUE_DEPTH = hfe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       has_byte,
    input  wire logic       end_of_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_out
);

    // job: {last of stream, data bit count, left-aligned data bits}
    localparam int MW = hfe_pkg::count_width(DATA_BITS);
    localparam int JW = DATA_BITS + MW + 1;

    logic          fq_valid, fq_ready;
    logic [JW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [JW-1:0] qb_data;

    // front: frame assembly, one job per full frame or stream end
    hfe_front #(
        .DATA_BITS (DATA_BITS),
        .MW        (MW),
        .JW        (JW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .end_of_data (end_of_data),
        .job_valid   (fq_valid),
        .job_ready   (fq_ready),
        .job_data    (fq_data)
    );

    // decoupling queue so either side can stall alone
    hfe_queue #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // back: codeword build and byte packing
    hfe_back #(
        .DATA_BITS (DATA_BITS),
        .MW        (MW),
        .JW        (JW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_out  (last_out)
    );

endmodule

`default_nettype wire

// ===== rtl/hfe_checker.sv =====
// hfe_checker: port-level checks for hamming_frame_encoder_unit
// no package dependencies; attached to the top level by the bind below
`default_nettype none

module hfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       end_of_data,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_out
);

    logic       seen_in_reg;
    logic [7:0] open_ends_reg;
    logic       in_fire, out_fire;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // ends accepted but not yet closed by a last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg   <= 1'b0;
            open_ends_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                seen_in_reg <= 1'b1;
            end
            if (open_ends_reg != 8'hff)
            begin
                if ((in_fire && end_of_data) && !(out_fire && last_out))
                begin
                    open_ends_reg <= open_ends_reg + 8'd1;
                end
                else if (!(in_fire && end_of_data) && (out_fire && last_out))
                begin
                    open_ends_reg <= open_ends_reg - 8'd1;
                end
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(last_out))
        else $error("output payload changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_in_reg)
        else $error("output byte with no input transaction");

    a_last_has_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && last_out |-> open_ends_reg != 8'd0)
        else $error("last byte without a pending end of data");

endmodule

bind hamming_frame_encoder_unit hfe_checker u_hfe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_data (end_of_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_out    (last_out)
);

`default_nettype wire
